// ===== rtl/ffa_pkg.sv =====
package ffa_pkg;

    // default sizes, handed to the top level parameters
    localparam int DEF_ARENA_BYTES  = 65536;
    localparam int DEF_FREE_ENTRIES = 32;

    // field widths fixed by the interface
    localparam int ADDR_W = 16;
    localparam int SIZE_W = 17;
    localparam int STAT_W = 3;

    localparam logic [SIZE_W-1:0] CAP_RESET = 17'h10000;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_FROM_LIST = 3'd0;
    localparam logic [STAT_W-1:0] STAT_FROM_BUMP = 3'd1;
    localparam logic [STAT_W-1:0] STAT_NO_SPACE  = 3'd2;
    localparam logic [STAT_W-1:0] STAT_FREED     = 3'd3;
    localparam logic [STAT_W-1:0] STAT_LIST_FULL = 3'd4;

    // request action codes
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // one free list entry
    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [SIZE_W-1:0] size;
    } t_entry;

endpackage

// ===== rtl/ffa_entry_ram.sv =====
module ffa_entry_ram #(
    parameter int DEPTH  = 32,
    parameter int IDX_W  = 5
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [IDX_W-1:0]     i_waddr,
    input  ffa_pkg::t_entry      i_wdata,
    input  logic [IDX_W-1:0]     i_raddr,
    output ffa_pkg::t_entry      o_rdata
);
    import ffa_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/first_fit_free_list_allocator_top.sv =====
// order: a free answers in the cycle after the transfer; an alloc scans the list from entry 0,
// answers on a hit, else gives a bump or out-of-space answer (straight to that step with an empty list)
// throughput: one request at a time; the single read port of the entry memory steps through
// the scan up to the hit, then the compaction of the entries behind
// reset: synchronous active low, clears entry count and bump head, capacity to 65536;
// entry memory is not cleared; results are strobed for one cycle, the receiver cannot stall
module first_fit_free_list_allocator_top #(
    parameter int ARENA_BYTES  = ffa_pkg::DEF_ARENA_BYTES,
    parameter int FREE_ENTRIES = ffa_pkg::DEF_FREE_ENTRIES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [ffa_pkg::SIZE_W-1:0]  i_cfg_wdata,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_action,
    input  logic [15:0]                 i_request_length,
    input  logic [ffa_pkg::ADDR_W-1:0]  i_block_address,
    output logic                        o_result_valid,
    output logic [ffa_pkg::STAT_W-1:0]  o_status,
    output logic [ffa_pkg::ADDR_W-1:0]  o_granted_address
);
    import ffa_pkg::*;

    localparam int IDX_W = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(FREE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FREE_ENTRIES);
    localparam logic [31:0] ARENA_LIM = 32'(ARENA_BYTES);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_SHIFT = 4'b0100,
        ST_BUMP  = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic [SIZE_W-1:0] r_capacity;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [SIZE_W-1:0] r_bump_head, n_bump_head;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [SIZE_W-1:0] r_need, n_need;
    logic              r_out_valid, n_out_valid;
    logic [STAT_W-1:0] r_status, n_status;
    logic [ADDR_W-1:0] r_granted, n_granted;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    t_entry            mem_wdata;
    logic [IDX_W-1:0]  mem_raddr;
    t_entry            mem_rdata;

    logic [SIZE_W-1:0] in_need;
    logic [CNT_W-1:0]  idx_p1;
    logic [SIZE_W-1:0] eff_cap;
    logic [SIZE_W:0]   bump_sum;
    logic              bump_fit;

    ffa_entry_ram #(
        .DEPTH (FREE_ENTRIES),
        .IDX_W (IDX_W)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign busy    = (r_state != ST_IDLE);
    assign in_need = {1'b0, i_request_length} + SIZE_W'(1);
    assign idx_p1  = CNT_W'(r_idx) + CNT_W'(1);

    // capacity limited by the arena size
    assign eff_cap  = (32'(r_capacity) > ARENA_LIM) ? SIZE_W'(ARENA_BYTES) : r_capacity;
    assign bump_sum = {1'b0, r_bump_head} + {1'b0, r_need};
    assign bump_fit = (bump_sum <= {1'b0, eff_cap});

    // sequencer: accept, scan, compaction, bump decision
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_bump_head = r_bump_head;
        n_idx       = r_idx;
        n_need      = r_need;
        n_out_valid = 1'b0;
        n_status    = r_status;
        n_granted   = r_granted;
        mem_we      = 1'b0;
        mem_waddr   = r_idx;
        mem_wdata   = mem_rdata;
        mem_raddr   = '0;

        unique case (r_state)
            ST_IDLE: begin
                mem_raddr = '0;
                if (start) begin
                    n_need = in_need;
                    n_idx  = '0;
                    if (i_action == ACT_FREE) begin
                        n_out_valid = 1'b1;
                        n_granted   = '0;
                        if (r_count < CNT_FULL) begin
                            mem_we          = 1'b1;
                            mem_waddr       = r_count[IDX_W-1:0];
                            mem_wdata.start = i_block_address;
                            mem_wdata.size  = in_need;
                            n_count         = r_count + CNT_W'(1);
                            n_status        = STAT_FREED;
                        end else begin
                            n_status = STAT_LIST_FULL;
                        end
                    end else if (r_count == '0) begin
                        n_state = ST_BUMP;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // entry r_idx is on the read data, fetch the one behind it
                mem_raddr = r_idx + IDX_W'(1);
                if (mem_rdata.size >= r_need) begin
                    n_out_valid = 1'b1;
                    n_status    = STAT_FROM_LIST;
                    n_granted   = mem_rdata.start;
                    if (mem_rdata.size == r_need) begin
                        n_state = ST_SHIFT;
                    end else begin
                        // cut the entry from its front
                        mem_we          = 1'b1;
                        mem_waddr       = r_idx;
                        mem_wdata.start = mem_rdata.start + r_need[ADDR_W-1:0];
                        mem_wdata.size  = mem_rdata.size - r_need;
                        n_state         = ST_IDLE;
                    end
                end else if (idx_p1 == r_count) begin
                    n_state = ST_BUMP;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            ST_SHIFT: begin
                // move entry r_idx+1 into place r_idx
                mem_raddr = r_idx + IDX_W'(2);
                if (idx_p1 >= r_count) begin
                    n_count = r_count - CNT_W'(1);
                    n_state = ST_IDLE;
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = r_idx;
                    mem_wdata = mem_rdata;
                    n_idx     = r_idx + IDX_W'(1);
                end
            end
            ST_BUMP: begin
                n_out_valid = 1'b1;
                n_state     = ST_IDLE;
                if (bump_fit) begin
                    n_status    = STAT_FROM_BUMP;
                    n_granted   = r_bump_head[ADDR_W-1:0];
                    n_bump_head = bump_sum[SIZE_W-1:0];
                end else begin
                    n_status  = STAT_NO_SPACE;
                    n_granted = '0;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_capacity  <= CAP_RESET;
            r_count     <= '0;
            r_bump_head <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_bump_head <= n_bump_head;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_need    <= n_need;
        r_status  <= n_status;
        r_granted <= n_granted;
    end

    assign o_result_valid    = r_out_valid;
    assign o_status          = r_status;
    assign o_granted_address = r_granted;

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ffa_pkg::*;

    localparam int ARENA_BYTES  = DEF_ARENA_BYTES;
    localparam int FREE_ENTRIES = DEF_FREE_ENTRIES;
    // pause before a capacity write, covers compaction after the last answer
    localparam int SETTLE_CYCLES = 2 * FREE_ENTRIES + 8;
    // cycles without any transfer before the run is declared hung
    localparam int STALL_LIMIT = 4000;
    localparam int ITEMS_PER_PHASE = 300;
    localparam int NUM_PHASES = 6;
    localparam int LIVE_MAX = 48;

    // one expected answer
    typedef struct {
        logic [STAT_W-1:0] status;
        logic [ADDR_W-1:0] granted;
    } t_answer;

    // a block handed out and not yet returned
    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic [15:0]       len;
    } t_grant;

    // one row of the directed table: a request or a capacity write
    typedef struct {
        bit                is_cfg;
        logic              act;
        logic [15:0]       len;
        logic [ADDR_W-1:0] addr;
        int                reps;
        bit                typed;
        logic [STAT_W-1:0] ex_status;
        logic [ADDR_W-1:0] ex_granted;
        logic [SIZE_W-1:0] cap;
    } t_stim_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [SIZE_W-1:0] i_cfg_wdata = '0;
    logic              start = 1'b0;
    logic              busy;
    logic              i_action = ACT_ALLOC;
    logic [15:0]       i_request_length = '0;
    logic [ADDR_W-1:0] i_block_address = '0;
    logic              o_result_valid;
    logic [STAT_W-1:0] o_status;
    logic [ADDR_W-1:0] o_granted_address;

    // shadow of the allocator state
    logic [ADDR_W-1:0] list_start [FREE_ENTRIES];
    logic [SIZE_W-1:0] list_size  [FREE_ENTRIES];
    int                list_count;
    logic [SIZE_W-1:0] bump_head;
    logic [SIZE_W-1:0] arena_cap;

    t_answer   pending_answers [$];
    t_grant    live_grants [$];
    t_stim_row dir_rows [$];
    int        mismatch_count = 0;
    int        idle_pct = 0;
    int        burst_left = 0;
    int        stall_cycles = 0;

    always #5 i_clk = ~i_clk;

    first_fit_free_list_allocator_top #(
        .ARENA_BYTES  (ARENA_BYTES),
        .FREE_ENTRIES (FREE_ENTRIES)
    ) u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .start             (start),
        .busy              (busy),
        .i_action          (i_action),
        .i_request_length  (i_request_length),
        .i_block_address   (i_block_address),
        .o_result_valid    (o_result_valid),
        .o_status          (o_status),
        .o_granted_address (o_granted_address)
    );

    // free insertion, first-fit search, exact-fit removal, front cut, bump fallback
    task automatic predict_request(input logic act, input logic [15:0] len,
                                   input logic [ADDR_W-1:0] addr,
                                   output logic [STAT_W-1:0] st,
                                   output logic [ADDR_W-1:0] grant);
        logic [SIZE_W-1:0] need;
        logic [SIZE_W:0]   cap_eff;
        int                hit;
        need = {1'b0, len} + 17'd1;
        grant = '0;
        hit = -1;
        if (act == ACT_FREE) begin
            if (list_count < FREE_ENTRIES) begin
                list_start[list_count] = addr;
                list_size[list_count] = need;
                list_count++;
                st = STAT_FREED;
            end else begin
                st = STAT_LIST_FULL;
            end
        end else begin
            for (int i = 0; i < list_count; i++) begin
                if (hit < 0 && list_size[i] >= need) hit = i;
            end
            if (hit >= 0) begin
                grant = list_start[hit];
                if (list_size[hit] == need) begin
                    for (int k = hit; k < list_count - 1; k++) begin
                        list_start[k] = list_start[k + 1];
                        list_size[k] = list_size[k + 1];
                    end
                    list_count--;
                end else begin
                    list_start[hit] = list_start[hit] + need[ADDR_W-1:0];
                    list_size[hit] = list_size[hit] - need;
                end
                st = STAT_FROM_LIST;
            end else begin
                cap_eff = (arena_cap > ARENA_BYTES) ? (SIZE_W+1)'(ARENA_BYTES)
                                                    : {1'b0, arena_cap};
                if ({1'b0, bump_head} + {1'b0, need} <= cap_eff) begin
                    grant = bump_head[ADDR_W-1:0];
                    bump_head = bump_head + need;
                    st = STAT_FROM_BUMP;
                end else begin
                    st = STAT_NO_SPACE;
                end
            end
        end
    endtask

    // drive one request, wait for its transfer, then queue the answer
    task automatic send_request(input logic act, input logic [15:0] len,
                                input logic [ADDR_W-1:0] addr, input bit typed,
                                input logic [STAT_W-1:0] ex_st,
                                input logic [ADDR_W-1:0] ex_grant);
        int                gap;
        logic [STAT_W-1:0] st;
        logic [ADDR_W-1:0] grant;
        t_answer           ans;
        t_grant            g;
        gap = 0;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(5, 20);
            while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct && gap < 200) gap++;
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_action <= act;
        i_request_length <= len;
        i_block_address <= addr;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_request(act, len, addr, st, grant);
        ans.status = typed ? ex_st : st;
        ans.granted = typed ? ex_grant : grant;
        pending_answers.insert(pending_answers.size(), ans);
        if (st == STAT_FROM_LIST || st == STAT_FROM_BUMP) begin
            g.addr = grant;
            g.len = len;
            live_grants.insert(live_grants.size(), g);
            if (live_grants.size() > LIVE_MAX) void'(live_grants.pop_front());
        end
    endtask

    // capacity write once the block has gone quiet
    task automatic write_capacity(input logic [SIZE_W-1:0] value);
        start <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        arena_cap = value;
    endtask

    // random mix: alloc/free pairs of live blocks plus noise
    task automatic pick_request(output logic act, output logic [15:0] len,
                                output logic [ADDR_W-1:0] addr);
        int     roll;
        int     idx;
        t_grant g;
        roll = $urandom_range(0, 99);
        act = ACT_ALLOC;
        len = 16'($urandom_range(0, 63));
        addr = 16'($urandom);
        if (roll < 40) begin
            if (live_grants.size() > 0 && $urandom_range(0, 1) == 1) begin
                len = live_grants[$urandom_range(0, live_grants.size() - 1)].len;
            end
        end else if (roll < 78) begin
            if (live_grants.size() > 0) begin
                idx = $urandom_range(0, live_grants.size() - 1);
                g = live_grants[idx];
                live_grants.delete(idx);
                act = ACT_FREE;
                len = g.len;
                addr = g.addr;
            end
        end else if (roll < 81) begin
            act = ACT_FREE;
            len = 16'($urandom);
        end else if (roll < 87) begin
            // take a large entry whole so big lengths reach the list
            for (int i = 0; i < list_count; i++) begin
                if (list_size[i] > 17'h08000) len = 16'(list_size[i] - 17'd1);
            end
        end else begin
            act = 1'($urandom_range(0, 1));
            len = 16'($urandom_range(0, 255));
        end
    endtask

    function automatic t_stim_row row_item(input logic act, input logic [15:0] len,
                                           input logic [ADDR_W-1:0] addr, input int reps,
                                           input bit typed, input logic [STAT_W-1:0] st,
                                           input logic [ADDR_W-1:0] grant);
        t_stim_row r;
        r.is_cfg = 1'b0;
        r.act = act;
        r.len = len;
        r.addr = addr;
        r.reps = reps;
        r.typed = typed;
        r.ex_status = st;
        r.ex_granted = grant;
        r.cap = '0;
        return r;
    endfunction

    function automatic t_stim_row row_cfg(input logic [SIZE_W-1:0] cap);
        t_stim_row r;
        r = row_item(ACT_ALLOC, '0, '0, 0, 1'b0, STAT_FROM_LIST, '0);
        r.is_cfg = 1'b1;
        r.cap = cap;
        return r;
    endfunction

    // append one row to the directed table
    function automatic void add_row(input t_stim_row r);
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    // answer checker
    always @(posedge i_clk) begin
        t_answer ans;
        if (i_rst_n && o_result_valid) begin
            if (pending_answers.size() == 0) begin
                $error("unexpected answer: status %0d granted_address %h",
                       o_status, o_granted_address);
                mismatch_count++;
            end else begin
                ans = pending_answers.pop_front();
                if (o_status !== ans.status) begin
                    $error("status: expected %0d, actual %0d", ans.status, o_status);
                    mismatch_count++;
                end
                if (o_granted_address !== ans.granted) begin
                    $error("granted_address: expected %h, actual %h",
                           ans.granted, o_granted_address);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid || i_cfg_we) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        logic              act;
        logic [15:0]       len;
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] cap;
        t_stim_row         row;

        list_count = 0;
        bump_head = '0;
        arena_cap = CAP_RESET;
        for (int i = 0; i < FREE_ENTRIES; i++) begin
            list_start[i] = '0;
            list_size[i] = '0;
        end

        // directed table
        add_row(row_item(ACT_ALLOC, 16'h0000, 16'hFFFF, 1, 1, STAT_FROM_BUMP, 16'h0000));
        add_row(row_item(ACT_FREE,  16'h0000, 16'h0000, 1, 1, STAT_FREED,     16'h0000));
        add_row(row_item(ACT_ALLOC, 16'h0000, 16'h0000, 1, 1, STAT_FROM_LIST, 16'h0000));
        add_row(row_item(ACT_ALLOC, 16'hFFFF, 16'h0000, 1, 1, STAT_NO_SPACE,  16'h0000));
        add_row(row_item(ACT_FREE,  16'hFFFF, 16'hFFFF, 1, 1, STAT_FREED,     16'h0000));
        // front cut wraps past the top of the address space
        add_row(row_item(ACT_ALLOC, 16'd9,    16'h0000, 1, 1, STAT_FROM_LIST, 16'hFFFF));
        add_row(row_item(ACT_ALLOC, 16'd0,    16'h0000, 1, 1, STAT_FROM_LIST, 16'h0009));
        add_row(row_item(ACT_FREE,  16'd2,    16'h1234, 1, 1, STAT_FREED,     16'h0000));
        // exact fit at the head, second entry moves up
        add_row(row_item(ACT_ALLOC, 16'd65524, 16'h0000, 1, 1, STAT_FROM_LIST, 16'h000A));
        add_row(row_item(ACT_ALLOC, 16'd2,    16'h0000, 1, 1, STAT_FROM_LIST, 16'h1234));
        // zero capacity
        add_row(row_cfg(17'd0));
        add_row(row_item(ACT_ALLOC, 16'd0,    16'h0000, 1, 1, STAT_NO_SPACE,  16'h0000));
        // bump fills capacity exactly, then runs out
        add_row(row_cfg(17'd300));
        add_row(row_item(ACT_ALLOC, 16'd298,  16'h0000, 1, 1, STAT_FROM_BUMP, 16'h0001));
        add_row(row_item(ACT_ALLOC, 16'd0,    16'h0000, 1, 1, STAT_NO_SPACE,  16'h0000));
        // capacity above the arena clamps to the arena
        add_row(row_cfg(17'h1FFFF));
        add_row(row_item(ACT_ALLOC, 16'd0,    16'h0000, 1, 1, STAT_FROM_BUMP, 16'h012C));
        // capacity lowered below the head
        add_row(row_cfg(17'd100));
        add_row(row_item(ACT_ALLOC, 16'd0,    16'h0000, 1, 1, STAT_NO_SPACE,  16'h0000));
        add_row(row_cfg(CAP_RESET));
        // fill the list, then one free too many
        add_row(row_item(ACT_FREE,  16'd7,    16'h8000, FREE_ENTRIES, 1, STAT_FREED,
                         16'h0000));
        add_row(row_item(ACT_FREE,  16'd0,    16'h0000, 1, 1, STAT_LIST_FULL, 16'h0000));
        // full scan with no fit falls back to bump
        add_row(row_item(ACT_ALLOC, 16'd8,    16'h0000, 1, 1, STAT_FROM_BUMP, 16'h012D));
        // exact fit at the head of a full list, longest compaction
        add_row(row_item(ACT_ALLOC, 16'd7,    16'h0000, 1, 1, STAT_FROM_LIST, 16'h8000));
        add_row(row_item(ACT_FREE,  16'hAAAA, 16'h5555, 1, 1, STAT_FREED,     16'h0000));
        // hit on the last entry
        add_row(row_item(ACT_ALLOC, 16'hAAAA, 16'h0000, 1, 1, STAT_FROM_LIST, 16'h5555));
        add_row(row_item(ACT_ALLOC, 16'd3,    16'h0000, 1, 0, STAT_FROM_LIST, 16'h0000));
        add_row(row_item(ACT_FREE,  16'd3,    16'hC0DE, 1, 0, STAT_FREED,     16'h0000));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            row = dir_rows[r];
            if (row.is_cfg) begin
                write_capacity(row.cap);
            end else begin
                repeat (row.reps) begin
                    send_request(row.act, row.len, row.addr, row.typed,
                                 row.ex_status, row.ex_granted);
                end
            end
        end

        // random phases: capacity setting and sender idling per phase
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: cap = CAP_RESET;
                1: cap = 17'h1FFFF;
                2: cap = 17'd0;
                3: cap = SIZE_W'(bump_head + 17'($urandom_range(0, 400)));
                4: cap = SIZE_W'($urandom_range(0, 131071));
                default: cap = CAP_RESET;
            endcase
            write_capacity(cap);
            case (p % 3)
                0: idle_pct = 0;
                1: idle_pct = 64;
                default: idle_pct = 16;
            endcase
            burst_left = 0;
            repeat (ITEMS_PER_PHASE) begin
                pick_request(act, len, addr);
                send_request(act, len, addr, 1'b0, STAT_FROM_LIST, '0);
            end
        end

        // drain and give the block time to show any stray answer
        start <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_answers.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ffa_pkg.sv
rtl/ffa_entry_ram.sv
rtl/first_fit_free_list_allocator_top.sv
tb/sv/testbench.sv
